// ===== hdl/mcu_direct_data_memory_sfr_map_core_defines.svh =====
// ----------------------------------------------------------------------------
// mdm assertion macros
// checks on the direct data memory and sfr map core, clocked on clk,
// held off during rst
// ----------------------------------------------------------------------------
`ifndef MCU_DIRECT_DATA_MEMORY_SFR_MAP_CORE_DEFINES_SVH
`define MCU_DIRECT_DATA_MEMORY_SFR_MAP_CORE_DEFINES_SVH

// same-cycle implication
`define MDM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mdm assertion failed");

// next-cycle implication
`define MDM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mdm assertion failed");

`endif

// ===== hdl/mdm_pkg.sv =====
// ----------------------------------------------------------------------------
// mdm_pkg
// shared types and address constants of the direct data memory and sfr map
// ----------------------------------------------------------------------------
`default_nettype none

package mdm_pkg;

  typedef enum logic [1:0] {
    CMD_DATA_RD = 2'd0,
    CMD_DATA_WR = 2'd1,
    CMD_CODE_RD = 2'd2,
    CMD_CODE_WR = 2'd3
  } cmd_t;

  // where the registered result byte comes from
  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_ONES,
    SRC_RAM,
    SRC_SFR,
    SRC_CODE
  } rd_src_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] rdata;
  } sfr_rsp_t;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } code_req_t;

  localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;
  localparam logic [7:0] PORT_RESET    = 8'hFF;
  localparam logic [7:0] SP_RESET      = 8'h07;
  localparam logic [7:0] SFR_SP        = 8'h81;

  localparam logic [7:0] PORT_ADDR [4] = '{8'h80, 8'h90, 8'hA0, 8'hB0};

  // acc, b, dpl, dph, ie, ip, pcon, psw, sbuf, scon, tcon, tmod, tl0, tl1, th0, th1
  localparam logic [7:0] OTHER_ADDR [16] = '{
    8'hE0, 8'hF0, 8'h82, 8'h83, 8'hA8, 8'hB8, 8'h87, 8'hD0,
    8'h99, 8'h98, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D
  };

endpackage

`default_nettype wire

// ===== hdl/mdm_sfr_file.sv =====
// ----------------------------------------------------------------------------
// mdm_sfr_file
// the 21 special function registers with their address decode
// ----------------------------------------------------------------------------
`default_nettype none

module mdm_sfr_file import mdm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire logic [7:0] addr,
  input  wire logic [7:0] wdata,
  output sfr_rsp_t        rsp
);

  logic [7:0]  port_reg [4];
  logic [7:0]  sp_reg;
  logic [7:0]  other_reg [16];
  logic [3:0]  port_hit;
  logic        sp_hit;
  logic [15:0] other_hit;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      port_hit[i] = (addr == PORT_ADDR[i]);
    end
    sp_hit = (addr == SFR_SP);
    for (int i = 0; i < 16; i++) begin
      other_hit[i] = (addr == OTHER_ADDR[i]);
    end
  end

  // one-hot select of the addressed register
  always_comb begin
    rsp.hit   = (|port_hit) || sp_hit || (|other_hit);
    rsp.rdata = sp_hit ? sp_reg : 8'h00;
    for (int i = 0; i < 4; i++) begin
      if (port_hit[i]) begin
        rsp.rdata = port_reg[i];
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (other_hit[i]) begin
        rsp.rdata = other_reg[i];
      end
    end
    if (!rsp.hit) begin
      rsp.rdata = UNMAPPED_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        port_reg[i] <= PORT_RESET;
      end
      sp_reg <= SP_RESET;
      for (int i = 0; i < 16; i++) begin
        other_reg[i] <= 8'h00;
      end
    end else if (wr_en) begin
      for (int i = 0; i < 4; i++) begin
        if (port_hit[i]) begin
          port_reg[i] <= wdata;
        end
      end
      if (sp_hit) begin
        sp_reg <= wdata;
      end
      for (int i = 0; i < 16; i++) begin
        if (other_hit[i]) begin
          other_reg[i] <= wdata;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mdm_code_store.sv =====
// ----------------------------------------------------------------------------
// mdm_code_store
// single-port code memory with registered read and a zeroing sweep after reset
// ----------------------------------------------------------------------------
`default_nettype none

module mdm_code_store import mdm_pkg::*; #(
  parameter int CODE_BYTES = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire code_req_t  req,
  output logic [7:0]      rdata,
  output logic            busy
);

  localparam int AW = $clog2(CODE_BYTES);

  logic [7:0]    mem [CODE_BYTES];
  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == AW'(CODE_BYTES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // the sweep owns the write port until it finishes
  always_comb begin
    wr_en   = busy || req.wr;
    wr_addr = busy ? clr_cnt : req.addr[AW-1:0];
    wr_data = busy ? 8'h00 : req.wdata;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd) begin
      rdata <= mem[req.addr[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mcu_direct_data_memory_sfr_map_core.sv =====
// ----------------------------------------------------------------------------
// mcu_direct_data_memory_sfr_map_core
// 8051-style memory map: 128-byte internal ram, 21 sfrs and a code store
//
// channel   ports                                      direction
// req       req_valid req_ready command address        in
//           write_value
// rsp       rsp_valid rsp_ready read_value mapped      out
//
// one transfer per cycle in each direction; a request produces its response
// in the cycle after it is accepted (registered ram, code and sfr read)
// after rst the code store is zeroed by a sweep over all CODE_BYTES entries; req_ready
// stays low until the sweep ends
// a stalled response holds req_ready low, so at most one response is pending
// ----------------------------------------------------------------------------
`default_nettype none

`include "mcu_direct_data_memory_sfr_map_core_defines.svh"

module mcu_direct_data_memory_sfr_map_core import mdm_pkg::*; #(
  parameter int CODE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [1:0]  command,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  write_value,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic [7:0]       read_value,
  output logic             mapped
);

  // request decode
  cmd_t      req_cmd;
  logic      req_fire;
  logic      is_ram;
  logic      code_hit;
  logic      code_busy;
  logic      wr_fire;
  logic      code_miss_fire;

  // internal ram with per-entry valid bits standing in for the zero reset
  logic [7:0]   ram_mem [128];
  logic [127:0] ram_vld;
  logic [7:0]   ram_q;
  logic         ram_q_vld;

  sfr_rsp_t  sfr_rsp;
  logic [7:0] sfr_q;
  code_req_t code_req;
  logic [7:0] code_q;

  // registered response control
  rd_src_t   src;
  rd_src_t   src_next;
  logic      mapped_next;

  assign req_cmd   = cmd_t'(command);
  assign req_ready = !code_busy && (!rsp_valid || rsp_ready);
  assign req_fire  = req_valid && req_ready;
  assign is_ram    = !address[7];
  assign code_hit  = ({1'b0, address} < 17'(CODE_BYTES));

  // accepted writes of either kind, and code reads past the store
  assign wr_fire        = req_fire && (req_cmd == CMD_DATA_WR || req_cmd == CMD_CODE_WR);
  assign code_miss_fire = req_fire && req_cmd == CMD_CODE_RD && !code_hit;

  // sfr block, written only by an accepted data write with address bit 7 set
  mdm_sfr_file u_sfr (
    .clk   (clk),
    .rst   (rst),
    .wr_en (req_fire && req_cmd == CMD_DATA_WR && !is_ram),
    .addr  (address[7:0]),
    .wdata (write_value),
    .rsp   (sfr_rsp)
  );

  always_comb begin
    code_req.rd    = req_fire && req_cmd == CMD_CODE_RD && code_hit;
    code_req.wr    = req_fire && req_cmd == CMD_CODE_WR && code_hit;
    code_req.addr  = address;
    code_req.wdata = write_value;
  end

  mdm_code_store #(
    .CODE_BYTES (CODE_BYTES)
  ) u_code (
    .clk   (clk),
    .rst   (rst),
    .req   (code_req),
    .rdata (code_q),
    .busy  (code_busy)
  );

  // ram array: one write or one read per cycle, read data registered
  always_ff @(posedge clk) begin
    if (req_fire && is_ram) begin
      if (req_cmd == CMD_DATA_WR) begin
        ram_mem[address[6:0]] <= write_value;
      end
      if (req_cmd == CMD_DATA_RD) begin
        ram_q <= ram_mem[address[6:0]];
      end
    end
  end

  // valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_vld   <= '0;
      ram_q_vld <= 1'b0;
    end else if (req_fire && is_ram) begin
      if (req_cmd == CMD_DATA_WR) begin
        ram_vld[address[6:0]] <= 1'b1;
      end
      if (req_cmd == CMD_DATA_RD) begin
        ram_q_vld <= ram_vld[address[6:0]];
      end
    end
  end

  // pick the result source and the hit flag for the accepted request
  always_comb begin
    src_next    = SRC_ZERO;
    mapped_next = 1'b0;
    unique case (req_cmd)
      CMD_DATA_RD: begin
        if (is_ram) begin
          src_next    = SRC_RAM;
          mapped_next = 1'b1;
        end else if (sfr_rsp.hit) begin
          src_next    = SRC_SFR;
          mapped_next = 1'b1;
        end else begin
          src_next    = SRC_ONES;
        end
      end
      CMD_DATA_WR: begin
        mapped_next = is_ram || sfr_rsp.hit;
      end
      CMD_CODE_RD: begin
        src_next    = code_hit ? SRC_CODE : SRC_ONES;
        mapped_next = code_hit;
      end
      CMD_CODE_WR: begin
        mapped_next = code_hit;
      end
      default: begin
        src_next    = SRC_ZERO;
        mapped_next = 1'b0;
      end
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      src    <= src_next;
      mapped <= mapped_next;
      sfr_q  <= sfr_rsp.rdata;
    end
  end

  // final byte select from the registered sources
  always_comb begin
    case (src)
      SRC_ZERO: read_value = 8'h00;
      SRC_ONES: read_value = UNMAPPED_BYTE;
      SRC_RAM:  read_value = ram_q_vld ? ram_q : 8'h00;
      SRC_SFR:  read_value = sfr_q;
      SRC_CODE: read_value = code_q;
      default:  read_value = 8'h00;
    endcase
  end

  // checks
  `MDM_ASSERT_IMPL(a_no_accept_in_sweep, code_busy, !req_ready)
  `MDM_ASSERT_NEXT(a_accept_gives_rsp, req_fire, rsp_valid)
  `MDM_ASSERT_NEXT(a_write_reads_zero, wr_fire, read_value == 8'h00)
  `MDM_ASSERT_NEXT(a_code_beyond_store, code_miss_fire, read_value == UNMAPPED_BYTE && !mapped)

endmodule

`default_nettype wire
